/* hdl/lidar_polar_to_world_points_core_defines.svh */
// Assertion macros for the lidar point core
`ifndef LIDAR_POLAR_TO_WORLD_POINTS_CORE_DEFINES_SVH
`define LIDAR_POLAR_TO_WORLD_POINTS_CORE_DEFINES_SVH
// implication checked every clock edge outside reset
`define LPW_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// next-cycle implication
`define LPW_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`endif

/* hdl/lpw_pkg.sv */
// Shared types, constants and CORDIC table for the lidar point core
package lpw_pkg;
	localparam int INDEX_BITS     = 12;
	localparam int CORDIC_STEPS   = 16;
	localparam int RANGE_LIMIT_MM = 1000000;
	localparam int FRAC_BITS      = 12;
	localparam int CORDIC_W       = 44;
	localparam int STEP_W         = $clog2(CORDIC_STEPS + 1);
	localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

	localparam logic [2:0] REG_ANGLE_STEP = 3'd0;
	localparam logic [2:0] REG_MOUNT_X    = 3'd1;
	localparam logic [2:0] REG_MOUNT_Y    = 3'd2;
	localparam logic [2:0] REG_POS_X      = 3'd3;
	localparam logic [2:0] REG_POS_Y      = 3'd4;
	localparam logic [2:0] REG_HEADING    = 3'd5;
	localparam logic [2:0] REG_SUBSAMPLE  = 3'd6;

	typedef struct packed {
		logic [15:0] range_mm;
		logic        range_invalid;
		logic        scan_end;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] local_x;
		logic signed [23:0] local_y;
		logic signed [23:0] world_x;
		logic signed [23:0] world_y;
		logic               local_keep;
		logic               world_keep;
		logic [11:0]        sample_index;
		logic               last_out;
	} out_item_t;

	// classified job handed from front to back
	typedef struct packed {
		logic [15:0] range_mm;
		logic        invalid;
		logic        on_grid;
		logic [15:0] beam_angle;
		logic [11:0] index;
		logic        last;
	} job_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
			5'd20: r = 32'd652;       5'd21: r = 32'd326;
			5'd22: r = 32'd163;       5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
		if (v > 32'sd8388607) return 24'sh7FFFFF;
		if (v < -32'sd8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic logic in_lim(input logic signed [31:0] v);
		logic signed [31:0] a;
		a = v[31] ? -v : v;
		return a < RANGE_LIMIT_MM;
	endfunction
endpackage

/* hdl/lpw_front.sv */
// Front end: sample indexing, beam angle and grid classification
module lpw_front import lpw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	input  logic [15:0] angle_step,
	input  logic [7:0]  subsample_step,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);
	logic [15:0] beam_angle_q;
	logic [7:0]  grid_phase_q;
	logic [11:0] sample_count_q;
	logic [7:0]  step;
	logic [8:0]  phase_inc;
	localparam int CAP_RAW = (1 << INDEX_BITS) - 1;
	localparam logic [11:0] CAP = (CAP_RAW > 4095) ? 12'd4095 : 12'(CAP_RAW);

	assign in_ready  = job_ready;
	assign job_valid = in_valid;
	assign step      = (subsample_step == 8'd0) ? 8'd1 : subsample_step;
	assign phase_inc = {1'b0, grid_phase_q} + 9'd1;

	always_comb begin
		job.range_mm   = in_data.range_mm;
		job.invalid    = in_data.range_invalid;
		job.on_grid    = grid_phase_q == 8'd0;
		job.beam_angle = beam_angle_q;
		job.index      = sample_count_q;
		job.last       = in_data.scan_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_angle_q   <= '0;
			grid_phase_q   <= '0;
			sample_count_q <= '0;
		end else if (in_valid && in_ready) begin
			if (in_data.scan_end) begin
				beam_angle_q   <= '0;
				grid_phase_q   <= '0;
				sample_count_q <= '0;
			end else begin
				beam_angle_q <= beam_angle_q + angle_step;
				grid_phase_q <= (phase_inc >= {1'b0, step}) ? 8'd0 : phase_inc[7:0];
				if (sample_count_q < CAP)
					sample_count_q <= sample_count_q + 12'd1;
			end
		end
	end
endmodule

/* hdl/lpw_queue.sv */
// Short job queue between front and back
module lpw_queue import lpw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

/* hdl/lpw_back.sv */
// Back end: two CORDIC rotations on one shared unit, descale, world translate
module lpw_back import lpw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  job_t               job,
	input  logic signed [15:0] mount_offset_x,
	input  logic signed [15:0] mount_offset_y,
	input  logic signed [23:0] platform_pos_x,
	input  logic signed [23:0] platform_pos_y,
	input  logic [15:0]        platform_heading,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_ITER = 3'd2;
	localparam logic [2:0] ST_MULA = 3'd3;
	localparam logic [2:0] ST_MULB = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]                 state_q;
	logic                       pass_q;   // 0 local, 1 world
	job_t                       job_q;
	logic signed [CORDIC_W-1:0] a_q, b_q;
	logic signed [33:0]         z_q;
	logic [STEP_W-1:0]          it_q;
	logic signed [CORDIC_W-1:0] ra_q;
	logic signed [31:0]         lx_q, ly_q;
	logic signed [31:0]         wx_q, wy_q;
	logic signed [31:0]         mul_res;
	logic signed [31:0]         mul_in;
	logic signed [63:0]         prod;
	logic signed [CORDIC_W-1:0] ax, bx, lda, ldb;
	logic signed [31:0]         vx, vy, wx, wy;
	logic [15:0]                ang;
	logic                       res_full_q;

	// descale: (v * 1/K + 2^41) >>> 42
	// rotated values stay below 2^30, so the low word of a and b is exact
	assign mul_in  = (state_q == ST_MULA) ? a_q[31:0] : b_q[31:0];
	assign prod    = mul_in * INV_GAIN_Q30 + (64'sd1 <<< (FRAC_BITS + 29));
	assign mul_res = {{10{prod[63]}}, prod[63:FRAC_BITS+30]};

	assign vx  = pass_q ? lx_q + 32'(mount_offset_x) : 32'(job_q.range_mm);
	assign vy  = pass_q ? ly_q + 32'(mount_offset_y) : 32'sd0;
	assign ang = pass_q ? platform_heading : job_q.beam_angle;

	assign wx = ra_q[31:0] + 32'(platform_pos_x);
	assign wy = mul_res + 32'(platform_pos_y);

	always_comb begin
		ax = CORDIC_W'(vx) <<< FRAC_BITS;
		bx = CORDIC_W'(vy) <<< FRAC_BITS;
		unique case (ang[15:14])
			2'd0: begin lda = ax;  ldb = bx;  end
			2'd1: begin lda = -bx; ldb = ax;  end
			2'd2: begin lda = -ax; ldb = -bx; end
			2'd3: begin lda = bx;  ldb = -ax; end
			default: begin lda = ax; ldb = bx; end
		endcase
	end

	assign job_ready = state_q == ST_IDLE;
	assign out_valid = res_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pass_q     <= 1'b0;
			res_full_q <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				res_full_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (job_valid) begin
					state_q <= job.invalid ? ST_DONE : ST_LOAD;
					pass_q  <= 1'b0;
				end
				ST_LOAD: state_q <= ST_ITER;
				ST_ITER: if (it_q == STEP_W'(CORDIC_STEPS - 1)) state_q <= ST_MULA;
				ST_MULA: state_q <= ST_MULB;
				ST_MULB: state_q <= pass_q ? ST_DONE : ST_LOAD;
				ST_DONE: if (!res_full_q || out_ready) begin
					state_q    <= ST_IDLE;
					res_full_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_MULB)
				pass_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (job_valid) job_q <= job;
			ST_LOAD: begin
				a_q  <= lda;
				b_q  <= ldb;
				z_q  <= 34'(ang[13:0]) <<< 16;
				it_q <= '0;
			end
			ST_ITER: begin
				if (!z_q[33]) begin
					a_q <= a_q - (b_q >>> it_q);
					b_q <= b_q + (a_q >>> it_q);
					z_q <= z_q - 34'(atan_lut(5'(it_q)));
				end else begin
					a_q <= a_q + (b_q >>> it_q);
					b_q <= b_q - (a_q >>> it_q);
					z_q <= z_q + 34'(atan_lut(5'(it_q)));
				end
				it_q <= it_q + STEP_W'(1);
			end
			ST_MULA: ra_q <= CORDIC_W'(mul_res);
			ST_MULB: if (!pass_q) begin
				lx_q <= ra_q[31:0];
				ly_q <= mul_res;
			end else begin
				wx_q <= wx;
				wy_q <= wy;
			end
			ST_DONE: if (!res_full_q || out_ready) begin
				if (job_q.invalid) begin
					out_data.local_x    <= '0;
					out_data.local_y    <= '0;
					out_data.world_x    <= '0;
					out_data.world_y    <= '0;
					out_data.local_keep <= 1'b0;
					out_data.world_keep <= 1'b0;
				end else begin
					out_data.local_x    <= sat24(lx_q);
					out_data.local_y    <= sat24(ly_q);
					out_data.world_x    <= sat24(wx_q);
					out_data.world_y    <= sat24(wy_q);
					out_data.local_keep <= job_q.on_grid && in_lim(lx_q) && in_lim(ly_q);
					out_data.world_keep <= job_q.on_grid && in_lim(wx_q) && in_lim(wy_q);
				end
				out_data.sample_index <= job_q.index;
				out_data.last_out     <= job_q.last;
			end
			default: ;
		endcase
	end
endmodule

/* hdl/lidar_polar_to_world_points_core.sv */
// The back handles one sample at a time, with the shared CORDIC unit
// running the local and world rotations in turn; the front and a two-entry
// queue take samples while the back is busy.
// Reset: arst_n asynchronous active low clears counters, queue pointers and the
// configuration registers to their reset values; no clearing pass.
`include "lidar_polar_to_world_points_core_defines.svh"
module lidar_polar_to_world_points_core import lpw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	localparam logic signed [23:0] LIM = 24'(RANGE_LIMIT_MM);

	logic [15:0]        angle_step_q, heading_q;
	logic signed [15:0] mount_x_q, mount_y_q;
	logic signed [23:0] pos_x_q, pos_y_q;
	logic [7:0]         subsample_q;
	logic               fj_valid, fj_ready, bj_valid, bj_ready;
	job_t               fj, bj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_step_q <= '0;
			mount_x_q    <= -16'sd64;
			mount_y_q    <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			heading_q    <= '0;
			subsample_q  <= 8'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANGLE_STEP: angle_step_q <= cfg_data[15:0];
				REG_MOUNT_X:    mount_x_q    <= cfg_data[15:0];
				REG_MOUNT_Y:    mount_y_q    <= cfg_data[15:0];
				REG_POS_X:      pos_x_q      <= cfg_data;
				REG_POS_Y:      pos_y_q      <= cfg_data;
				REG_HEADING:    heading_q    <= cfg_data[15:0];
				REG_SUBSAMPLE:  subsample_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lpw_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.angle_step(angle_step_q), .subsample_step(subsample_q),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	lpw_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
	);

	lpw_back u_back (
		.clk, .arst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.mount_offset_x(mount_x_q), .mount_offset_y(mount_y_q),
		.platform_pos_x(pos_x_q), .platform_pos_y(pos_y_q),
		.platform_heading(heading_q), .out_valid, .out_ready, .out_data
	);

	`LPW_ASSERT_IMP(a_world_keep_lim, out_valid && out_data.world_keep, out_data.world_x < LIM)
	`LPW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`LPW_ASSERT_IMP(a_local_keep_lim, out_valid && out_data.local_keep, out_data.local_y > -LIM)
endmodule

/* tb/sv/lidar_polar_to_world_points_core_checker.sv */
`timescale 1ns / 100ps
// Point checker: watches the sample and point channels, predicts each point and compares
module lidar_polar_to_world_points_core_checker import lpw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          pending
);
	localparam longint ATAN [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81};

	logic [15:0]        step_q;
	logic signed [15:0] mnt_x, mnt_y;
	logic signed [23:0] pos_x, pos_y;
	logic [15:0]        heading;
	logic [7:0]         subs;
	logic [15:0]        beam;
	logic [7:0]         phase;
	logic [11:0]        count;
	out_item_t          point_q[$];

	assign pending = point_q.size();

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unscale(longint v);
		return shr(v * 64'sd652032874 + (64'sd1 <<< 41), 42);
	endfunction

	task automatic turn(input longint x, input longint y, input logic [15:0] ang,
			output longint ox, output longint oy);
		longint a, b, t, z, da, db;
		a = x * 4096;
		b = y * 4096;
		case (ang[15:14])
			2'd1: begin t = a; a = -b; b = t; end
			2'd2: begin a = -a; b = -b; end
			2'd3: begin t = a; a = b; b = -t; end
			default: ;
		endcase
		z = longint'(ang[13:0]) * 65536;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			da = shr(b, i);
			db = shr(a, i);
			if (z >= 0) begin
				a -= da; b += db; z -= ATAN[i];
			end else begin
				a += da; b -= db; z += ATAN[i];
			end
		end
		ox = unscale(a);
		oy = unscale(b);
	endtask

	function automatic logic [23:0] clip(longint v);
		if (v > 8388607) return 24'h7FFFFF;
		if (v < -8388608) return 24'h800000;
		return v[23:0];
	endfunction

	function automatic bit in_range(longint x, longint y);
		longint ax, ay;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		return ax < RANGE_LIMIT_MM && ay < RANGE_LIMIT_MM;
	endfunction

	task automatic predict_point(input in_item_t s);
		out_item_t p;
		longint lx, ly, rx, ry, wx, wy;
		logic [7:0] st;
		bit grid;
		st = subs == 0 ? 8'd1 : subs;
		grid = phase == 0;
		lx = 0; ly = 0; wx = 0; wy = 0;
		p = '0;
		if (!s.range_invalid) begin
			turn(longint'(s.range_mm), 0, beam, lx, ly);
			turn(lx + mnt_x, ly + mnt_y, heading, rx, ry);
			wx = rx + pos_x;
			wy = ry + pos_y;
			p.local_keep = grid && in_range(lx, ly);
			p.world_keep = grid && in_range(wx, wy);
		end
		p.local_x = clip(lx);
		p.local_y = clip(ly);
		p.world_x = clip(wx);
		p.world_y = clip(wy);
		p.sample_index = count;
		p.last_out = s.scan_end;
		point_q = {point_q, p};
		if (s.scan_end) begin
			beam = 0; phase = 0; count = 0;
		end else begin
			beam = beam + step_q;
			phase = (int'(phase) + 1 >= int'(st)) ? 8'd0 : phase + 8'd1;
			if (count != 12'hFFF) count = count + 12'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			step_q = 0; mnt_x = -16'sd64; mnt_y = 0; pos_x = 0; pos_y = 0;
			heading = 0; subs = 8'd10; beam = 0; phase = 0; count = 0;
			errors = 0;
			point_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ANGLE_STEP: step_q = cfg_data[15:0];
					REG_MOUNT_X:    mnt_x = cfg_data[15:0];
					REG_MOUNT_Y:    mnt_y = cfg_data[15:0];
					REG_POS_X:      pos_x = cfg_data;
					REG_POS_Y:      pos_y = cfg_data;
					REG_HEADING:    heading = cfg_data[15:0];
					REG_SUBSAMPLE:  subs = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_point(in_data);
			if (out_valid && out_ready) begin
				if (point_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected point, expected none, actual %p", $time, out_data);
				end else begin
					e = point_q.pop_front();
					if (e != out_data) begin
						errors++;
						$display("%0t: point mismatch, expected %p, actual %p",
							$time, e, out_data);
					end
				end
			end
		end
	end
endmodule

/* tb/sv/lidar_polar_to_world_points_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top: drives scans and register settings, gives the verdict
module lidar_polar_to_world_points_core_tb;
	import lpw_pkg::*;

	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	int          errors;
	int          pending;
	int          idle_pct;
	int          quiet = 0;

	lidar_polar_to_world_points_core u_dut (.*);

	lidar_polar_to_world_points_core_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// sink stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= $urandom_range(99) >= idle_pct;
	end

	// watchdog on transfers
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	// valid stays high from one transfer into the next; idling or drain drops it
	task automatic send_sample(input logic [15:0] rng, input logic bad, input logic last);
		cfg_we <= 1'b0;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{range_mm: rng, range_invalid: bad, scan_end: last};
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// write enable is dropped by the next sample or drain
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic random_regs(input bit wild);
		write_reg(REG_ANGLE_STEP, $urandom_range(65535));
		write_reg(REG_MOUNT_X, wild ? $urandom : $urandom_range(400) - 200);
		write_reg(REG_MOUNT_Y, wild ? $urandom : $urandom_range(400) - 200);
		write_reg(REG_POS_X, wild ? $urandom : $urandom_range(4000000) - 2000000);
		write_reg(REG_POS_Y, wild ? $urandom : $urandom_range(4000000) - 2000000);
		write_reg(REG_HEADING, $urandom_range(65535));
		write_reg(REG_SUBSAMPLE, $urandom_range(255));
	endtask

	task automatic random_scans(input int n);
		int k;
		k = 0;
		while (k < n) begin
			send_sample($urandom_range(3) == 0 ? 16'hFFFF - $urandom_range(3) : $urandom,
				$urandom_range(9) == 0, $urandom_range(24) == 0 || k == n - 1);
			k++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 29;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, range extremes, invalid and scan end
		send_sample(16'd0, 1'b0, 1'b0);
		send_sample(16'hFFFF, 1'b0, 1'b0);
		send_sample(16'h8000, 1'b1, 1'b0);
		send_sample(16'd1000, 1'b0, 1'b1);
		drain();
		// quarter-turn steps cover every quadrant; step one keeps every sample
		write_reg(REG_ANGLE_STEP, 24'h4000);
		write_reg(REG_SUBSAMPLE, 24'd1);
		write_reg(REG_MOUNT_X, 24'h007FFF);
		write_reg(REG_MOUNT_Y, 24'hFF8000);
		write_reg(REG_POS_X, 24'h7FFFFF);
		write_reg(REG_POS_Y, 24'h800000);
		write_reg(REG_HEADING, 24'hFFFF);
		for (int i = 0; i < 6; i++)
			send_sample(16'hFFFF, 1'b0, i == 5);
		drain();
		// step zero acts as one; odd angle step
		write_reg(REG_SUBSAMPLE, 24'd0);
		write_reg(REG_ANGLE_STEP, 24'hFFFF);
		write_reg(REG_HEADING, 24'h8000);
		write_reg(REG_POS_X, 24'd0);
		write_reg(REG_POS_Y, 24'd0);
		for (int i = 0; i < 4; i++)
			send_sample(16'd50000 + i, 1'b0, 1'b0);
		drain();
		// lower the step mid-scan so the phase wraps
		write_reg(REG_SUBSAMPLE, 24'd255);
		for (int i = 0; i < 3; i++)
			send_sample(16'd300, 1'b0, 1'b0);
		drain();
		write_reg(REG_SUBSAMPLE, 24'd2);
		for (int i = 0; i < 3; i++)
			send_sample(16'd300, 1'b0, i == 2);
		drain();

		// random phases; the middle one has no idling on either side
		for (int ph = 0; ph < 5; ph++) begin
			random_regs(ph[0]);
			idle_pct = ph == 2 ? 0 : 29;
			random_scans(100);
			drain();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
